// ===== rtl/core/knn_pkg.sv =====
// ----------------------------------------------------------------------------
// knn_pkg
// Shared types and constants for the per-plane k-nearest insertion block.
// ----------------------------------------------------------------------------
package knn_pkg;

  localparam int DIST_W  = 34;
  localparam int IDX_W   = 16;
  localparam int COORD_W = 16;
  localparam int SQ_W    = 32;
  localparam int PLANES  = 3;

  // fill distance after reset
  localparam logic [DIST_W-1:0] IW_RESET = 34'd16777216;

  // color plane codes
  typedef enum logic [1:0] {
    PLANE_RED   = 2'd0,
    PLANE_GREEN = 2'd1,
    PLANE_BLUE  = 2'd2,
    PLANE_NONE  = 2'd3
  } plane_t;

  // one list entry
  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [IDX_W-1:0]  index;
  } entry_t;

  // candidate after the squaring stage
  typedef struct packed {
    logic             start_group;
    logic             end_group;
    plane_t           plane;
    logic [SQ_W-1:0]  sq_x;
    logic [SQ_W-1:0]  sq_y;
    logic [IDX_W-1:0] index;
  } cand_t;

endpackage

// ===== rtl/core/knn_if.sv =====
// ----------------------------------------------------------------------------
// knn channel interfaces
// Candidate input channel and list entry output channel, valid/ready.
// ----------------------------------------------------------------------------
interface knn_in_if;
  logic        valid;
  logic        ready;
  logic        start_group;
  logic        end_group;
  logic signed [15:0] cur_x;
  logic signed [15:0] cur_y;
  logic signed [15:0] cand_x;
  logic signed [15:0] cand_y;
  logic [15:0] cand_index;
  logic [1:0]  cand_plane;

  modport source (
    output valid, start_group, end_group, cur_x, cur_y, cand_x, cand_y,
           cand_index, cand_plane,
    input  ready
  );
  modport sink (
    input  valid, start_group, end_group, cur_x, cur_y, cand_x, cand_y,
           cand_index, cand_plane,
    output ready
  );
endinterface

interface knn_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  plane;
  logic [1:0]  rank;
  logic [33:0] sq_distance;
  logic [15:0] neighbor_index;
  logic        last_of_run;

  modport source (
    output valid, plane, rank, sq_distance, neighbor_index, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, plane, rank, sq_distance, neighbor_index, last_of_run,
    output ready
  );
endinterface

// ===== rtl/core/k_nearest_per_plane_insert.sv =====
// ----------------------------------------------------------------------------
// k_nearest_per_plane_insert
// Keeps three sorted lists of the NEIGHBORS nearest candidates, one per
// color plane, and emits all of them at the end of a group.
// ----------------------------------------------------------------------------
// Usage:
//   cand carries one candidate a beat; start_group refills every list with
//   initial_weight before the candidate is applied, end_group emits all
//   3*NEIGHBORS entries after it. result gives the entries plane by plane,
//   nearest first, with last_of_run on the final one.
//   cfg_we/cfg_wdata write initial_weight; it applies from the next start.
// Timing:
//   one candidate per cycle while no end beat waits. A beat is squared and
//   registered in the input stage, then inserted by the cell row; the first
//   entry of a run is valid in the cycle after the end beat is taken, then
//   one entry a cycle while result is ready. The run leaves through a
//   snapshot shift line, so candidates keep flowing while it drains; only
//   the next end beat waits for that line to empty.
// Reset:
//   rst clears the pipeline and output run, lists read initial_weight reset
//   value with index 0. A stalled result holds the shift line in place.
// ----------------------------------------------------------------------------
module k_nearest_per_plane_insert #(
  parameter int NEIGHBORS = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [knn_pkg::DIST_W-1:0] cfg_wdata,
  knn_in_if.sink                     cand,
  knn_out_if.source                  result
);

  localparam int ENTRIES = knn_pkg::PLANES * NEIGHBORS;

  logic [knn_pkg::DIST_W-1:0] initial_weight;
  logic                       stage_valid;
  knn_pkg::cand_t             stage;
  logic                       advance;
  logic                       fire;
  logic                       snap_free;
  logic [knn_pkg::DIST_W:0]   dist_sum;
  logic [knn_pkg::DIST_W-1:0] cand_dist;
  knn_pkg::entry_t            eff [ENTRIES];
  knn_pkg::entry_t            nxt [ENTRIES];
  logic                       hit [ENTRIES];

  // fill distance register
  always_ff @(posedge clk) begin
    if (rst) begin
      initial_weight <= knn_pkg::IW_RESET;
    end else if (cfg_we) begin
      initial_weight <= cfg_wdata;
    end
  end

  knn_dist u_dist (
    .clk         (clk),
    .rst         (rst),
    .cand        (cand),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage       (stage)
  );

  // an end beat waits until the snapshot line is free
  assign advance = !stage.end_group || snap_free;
  assign fire    = stage_valid && advance;

  // squared distance, clamped to the field range
  assign dist_sum  = (knn_pkg::DIST_W+1)'(stage.sq_x) + (knn_pkg::DIST_W+1)'(stage.sq_y);
  assign cand_dist = dist_sum[knn_pkg::DIST_W] ? '1 : dist_sum[knn_pkg::DIST_W-1:0];

  // row of cells, one chain per plane
  for (genvar p = 0; p < knn_pkg::PLANES; p++) begin : g_plane
    for (genvar k = 0; k < NEIGHBORS; k++) begin : g_cell
      localparam int E = p * NEIGHBORS + k;
      logic            hin;
      knn_pkg::entry_t pin;

      if (k == 0) begin : g_head
        assign hin = 1'b0;
        assign pin = eff[E];
      end else begin : g_link
        assign hin = hit[E-1];
        assign pin = eff[E-1];
      end

      knn_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .fire        (fire),
        .sel         (stage.plane == knn_pkg::plane_t'(p)),
        .start       (stage.start_group),
        .init_weight (initial_weight),
        .cand_dist   (cand_dist),
        .index       (stage.index),
        .hit_in      (hin),
        .prev        (pin),
        .cur         (eff[E]),
        .hit_out     (hit[E]),
        .next        (nxt[E])
      );
    end
  end

  knn_emit #(
    .NEIGHBORS (NEIGHBORS)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (fire && stage.end_group),
    .fill      (nxt),
    .snap_free (snap_free),
    .result    (result)
  );

endmodule

// ===== rtl/core/knn_dist.sv =====
// ----------------------------------------------------------------------------
// knn_dist
// Input stage: absolute coordinate differences, squared and registered.
// ----------------------------------------------------------------------------
module knn_dist (
  input  logic           clk,
  input  logic           rst,
  knn_in_if.sink         cand,
  input  logic           advance,
  output logic           stage_valid,
  output knn_pkg::cand_t stage
);

  logic signed [16:0] dx_s;
  logic signed [16:0] dy_s;
  logic [16:0]        dx_n;
  logic [16:0]        dy_n;
  logic [15:0]        dx_mag;
  logic [15:0]        dy_mag;
  logic [knn_pkg::SQ_W-1:0] sq_x;
  logic [knn_pkg::SQ_W-1:0] sq_y;

  // differences at 17 bits, magnitude fits 16
  assign dx_s   = {cand.cur_x[15], cand.cur_x} - {cand.cand_x[15], cand.cand_x};
  assign dy_s   = {cand.cur_y[15], cand.cur_y} - {cand.cand_y[15], cand.cand_y};
  assign dx_n   = dx_s[16] ? 17'(-dx_s) : 17'(dx_s);
  assign dy_n   = dy_s[16] ? 17'(-dy_s) : 17'(dy_s);
  assign dx_mag = dx_n[15:0];
  assign dy_mag = dy_n[15:0];

  // one 16x16 square per axis
  assign sq_x = dx_mag * dx_mag;
  assign sq_y = dy_mag * dy_mag;

  // stage holds while the cell row cannot take it
  assign cand.ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (cand.ready) begin
      stage_valid <= cand.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cand.valid && cand.ready) begin
      stage.start_group <= cand.start_group;
      stage.end_group   <= cand.end_group;
      stage.plane       <= knn_pkg::plane_t'(cand.cand_plane);
      stage.sq_x        <= sq_x;
      stage.sq_y        <= sq_y;
      stage.index       <= cand.cand_index;
    end
  end

endmodule

// ===== rtl/core/knn_cell.sv =====
// ----------------------------------------------------------------------------
// knn_cell
// One list entry: compares the candidate distance and keeps, takes the
// candidate, or takes the entry of the nearer neighbor cell.
// ----------------------------------------------------------------------------
module knn_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        fire,
  input  logic                        sel,
  input  logic                        start,
  input  logic [knn_pkg::DIST_W-1:0]  init_weight,
  input  logic [knn_pkg::DIST_W-1:0]  cand_dist,
  input  logic [knn_pkg::IDX_W-1:0]   index,
  input  logic                        hit_in,
  input  knn_pkg::entry_t             prev,
  output knn_pkg::entry_t             cur,
  output logic                        hit_out,
  output knn_pkg::entry_t             next
);

  knn_pkg::entry_t held;
  logic            less;

  // refill on start happens before the compare
  always_comb begin
    if (start) begin
      cur.distance = init_weight;
      cur.index    = '0;
    end else begin
      cur = held;
    end
  end

  assign less    = cand_dist < cur.distance;
  assign hit_out = hit_in || less;

  // insert at the first entry that is strictly farther, shift the rest down
  always_comb begin
    next = cur;
    if (sel) begin
      if (hit_in) begin
        next = prev;
      end else if (less) begin
        next.distance = cand_dist;
        next.index    = index;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held.distance <= knn_pkg::IW_RESET;
      held.index    <= '0;
    end else if (fire) begin
      held <= next;
    end
  end

endmodule

// ===== rtl/core/knn_emit.sv =====
// ----------------------------------------------------------------------------
// knn_emit
// Snapshot of all lists taken on an end beat, shifted out one entry a beat.
// ----------------------------------------------------------------------------
module knn_emit #(
  parameter int NEIGHBORS = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  knn_pkg::entry_t fill [knn_pkg::PLANES*NEIGHBORS],
  output logic            snap_free,
  knn_out_if.source       result
);

  localparam int ENTRIES = knn_pkg::PLANES * NEIGHBORS;
  localparam int CW      = $clog2(ENTRIES + 1);
  localparam int RW      = $clog2(NEIGHBORS + 1);

  knn_pkg::entry_t snap [ENTRIES];
  logic [CW-1:0]   count;
  logic [RW-1:0]   rank_cnt;
  logic [1:0]      plane_cnt;
  logic [RW+1:0]   rank_ext;
  logic            pop;

  assign pop       = result.valid && result.ready;
  assign snap_free = (count == '0) || (count == CW'(1) && result.ready);

  // run position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rank_cnt  <= '0;
      plane_cnt <= '0;
    end else if (load) begin
      count     <= CW'(ENTRIES);
      rank_cnt  <= '0;
      plane_cnt <= '0;
    end else if (pop) begin
      count <= count - CW'(1);
      if (rank_cnt == RW'(NEIGHBORS - 1)) begin
        rank_cnt  <= '0;
        plane_cnt <= plane_cnt + 2'd1;
      end else begin
        rank_cnt <= rank_cnt + RW'(1);
      end
    end
  end

  // shift line, head is the output register
  for (genvar i = 0; i < ENTRIES; i++) begin : g_snap
    if (i < ENTRIES - 1) begin : g_mid
      always_ff @(posedge clk) begin
        if (load) begin
          snap[i] <= fill[i];
        end else if (pop) begin
          snap[i] <= snap[i+1];
        end
      end
    end else begin : g_tail
      always_ff @(posedge clk) begin
        if (load) begin
          snap[i] <= fill[i];
        end
      end
    end
  end

  assign rank_ext              = {2'b00, rank_cnt};
  assign result.valid          = count != '0;
  assign result.plane          = plane_cnt;
  assign result.rank           = rank_ext[1:0];
  assign result.sq_distance    = snap[0].distance;
  assign result.neighbor_index = snap[0].index;
  assign result.last_of_run    = count == CW'(1);

endmodule
